@@ hdl/online_softmax_cross_entropy_core_macros.svh @@
// Assertion macros shared by the online softmax cross-entropy RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ONLINE_SOFTMAX_CROSS_ENTROPY_CORE_MACROS_SVH
`define ONLINE_SOFTMAX_CROSS_ENTROPY_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define OSCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("osce assertion failed");
`define OSCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("osce assertion failed");
`else
`define OSCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OSCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/osce_pkg.sv @@
// Package for the online softmax cross-entropy core: widths, item types,
// state encodings and the exponent table builder. No dependencies.
package osce_pkg;

    localparam int MAX_ROWS       = 1024;
    localparam int EXP_TABLE_BITS = 10;
    localparam int EXP_SHIFT      = 14 - EXP_TABLE_BITS;
    localparam int EXP_ENTRIES    = 1 << EXP_TABLE_BITS;
    localparam int LOGIT_W        = 16;
    localparam int EXP_W          = 17;
    localparam int SUM_W          = 32;
    localparam int TOTAL_W        = 40;
    localparam int LOSS_W         = 24;
    localparam int LN_W           = 20;
    localparam int ROWS_W         = $clog2(MAX_ROWS + 1);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [SUM_W-1:0]  ONE_Q16  = SUM_W'(65536);
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [LOSS_W-1:0] OUT_MAX  = '1;
    localparam logic [31:0]       LN2_Q32  = 32'd2977044472;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic                      is_target;
        logic                      last_in_row;
        logic                      last_row;
    } osce_in_t;

    typedef struct packed {
        logic [LOSS_W-1:0] row_loss;
        logic [LOSS_W-1:0] mean_loss;
        logic              is_final;
        logic              sum_saturated;
    } osce_out_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_LOOK, BK_MUL, BK_LN_GO, BK_LN_WAIT,
        BK_LOSS, BK_TOT, BK_DIV_GO, BK_DIV_WAIT, BK_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        LN_IDLE, LN_NORM, LN_SQ, LN_MUL, LN_RND
    } ln_state_t;

    typedef logic [EXP_W-1:0] exp_rom_t [EXP_ENTRIES];

    // exp(-d) for d in Q4.10, Q1.16 result: Taylor series of exp(-d/64) in
    // Q2.30, squared six times.
    function automatic logic [EXP_W-1:0] exp_entry(input int unsigned d_q10);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] v;
        y    = 64'(d_q10) << 14;
        term = 64'd1 << 30;
        v    = term;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * y) >> 30) / 64'(n);
            if ((n & 1) != 0)
                v = v - term;
            else
                v = v + term;
        end
        for (int k = 0; k < 6; k++)
            v = (v * v + (64'd1 << 29)) >> 30;
        return EXP_W'((v + (64'd1 << 13)) >> 14);
    endfunction

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t rom;
        for (int i = 0; i < EXP_ENTRIES; i++)
            rom[i] = exp_entry(int'(unsigned'(i)) << EXP_SHIFT);
        return rom;
    endfunction

endpackage

@@ hdl/online_softmax_cross_entropy_core.sv @@
// Online softmax cross-entropy core, top level: input queue and back end.
// Depends on osce_pkg, osce_queue and osce_back.
//
// Usage: logits enter on the logit channel (logit_valid / logit_stall /
// logit_item), one item per class, rows back to back; last_in_row closes a
// row and last_row on that item closes the batch. Each closed row gives one
// item on the loss channel (loss_valid / loss_stall / loss_item) with the
// row loss, and on the last row the batch mean with is_final set.
// Per logit: the back end reads the exponent table, and when it raises the
// row maximum, also does a 32x17 multiply and rescale add; it takes the next
// logit only when it is through with the last. Row end: the log unit normalizes,
// then squares once per fraction bit, then multiplies and rounds; the loss and
// total steps follow, and a batch close adds the 40-bit divider.
// A four-entry input queue lets the sender keep going during a row close.
// Reset clears all running state; the exponent table is a constant ROM, so
// no clearing pass is needed. When the receiver stalls, the result holds in
// the output register and the back end waits there; the queue keeps
// accepting logits until it fills.
module online_softmax_cross_entropy_core import osce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      logit_valid,
    output logic      logit_stall,
    input  osce_in_t  logit_item,
    output logic      loss_valid,
    input  logic      loss_stall,
    output osce_out_t loss_item
);

    logic     head_valid;
    osce_in_t head_item;
    logic     pop;

    osce_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .logit_valid (logit_valid),
        .logit_stall (logit_stall),
        .logit_item  (logit_item),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop)
    );

    osce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .loss_valid (loss_valid),
        .loss_stall (loss_stall),
        .loss_item  (loss_item)
    );

endmodule

@@ hdl/osce_queue.sv @@
// Front end: accepts logit items and holds them in a short queue for the
// back end. Depends on osce_pkg.
module osce_queue import osce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     logit_valid,
    output logic     logit_stall,
    input  osce_in_t logit_item,
    output logic     head_valid,
    output osce_in_t head_item,
    input  logic     pop
);

    osce_in_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                push, do_pop;

    assign logit_stall = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push        = logit_valid && !logit_stall;
    assign head_valid  = (count_reg != '0);
    assign head_item   = slot_reg[rd_ptr_reg];
    assign do_pop      = pop && head_valid;

    always_ff @(posedge clk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= logit_item;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ hdl/osce_ln.sv @@
// Iterative natural log of an unsigned Q16.16 value, Q16 result, 0 below 1.0.
// Normalizes one bit a cycle, then squares once per fraction bit. Uses osce_pkg.
module osce_ln import osce_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SUM_W-1:0] x,
    output logic            done,
    output logic [LN_W-1:0] result
);

    ln_state_t        state_reg, state_next;
    logic [SUM_W-1:0] norm_reg, norm_next;
    logic [3:0]       shift_reg, shift_next;
    logic [30:0]      m_reg, m_next;
    logic [15:0]      frac_reg, frac_next;
    logic [3:0]       iter_reg, iter_next;
    logic [51:0]      prod_reg, prod_next;
    logic [LN_W-1:0]  result_reg, result_next;
    logic             done_reg, done_next;
    logic [61:0]      sq;
    logic [31:0]      sq_top;
    logic [52:0]      rounded;

    assign sq      = 62'(m_reg) * 62'(m_reg);
    assign sq_top  = sq[61:30];
    assign rounded = 53'(prod_reg) + (53'd1 << 31);
    assign done    = done_reg;
    assign result  = result_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            LN_IDLE: if (start) state_next = (x[SUM_W-1:16] == '0) ? LN_IDLE : LN_NORM;
            LN_NORM: if (norm_reg[SUM_W-1]) state_next = LN_SQ;
            LN_SQ:   if (iter_reg == 4'd15) state_next = LN_MUL;
            LN_MUL:  state_next = LN_RND;
            LN_RND:  state_next = LN_IDLE;
            default: state_next = LN_IDLE;
        endcase
    end

    always_comb begin
        norm_next   = norm_reg;
        shift_next  = shift_reg;
        m_next      = m_reg;
        frac_next   = frac_reg;
        iter_next   = iter_reg;
        prod_next   = prod_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            LN_IDLE: begin
                if (start) begin
                    norm_next  = x;
                    shift_next = '0;
                    if (x[SUM_W-1:16] == '0) begin
                        result_next = '0;
                        done_next   = 1'b1;
                    end
                end
            end
            LN_NORM: begin
                if (norm_reg[SUM_W-1]) begin
                    m_next    = norm_reg[SUM_W-1:1];
                    iter_next = '0;
                    frac_next = '0;
                end
                else begin
                    norm_next  = norm_reg << 1;
                    shift_next = shift_reg + 1'b1;
                end
            end
            LN_SQ: begin
                // A square of 2.0 or more yields the next log2 fraction bit.
                if (sq_top[31]) begin
                    m_next    = sq_top[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else begin
                    m_next    = sq_top[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
            end
            LN_MUL: prod_next = 52'({4'(4'd15 - shift_reg), frac_reg}) * 52'(LN2_Q32);
            LN_RND: begin
                result_next = rounded[32 +: LN_W];
                done_next   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk) begin
        norm_reg   <= norm_next;
        shift_reg  <= shift_next;
        m_reg      <= m_next;
        frac_reg   <= frac_next;
        iter_reg   <= iter_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= LN_IDLE;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

@@ hdl/osce_div.sv @@
// Restoring divider, one quotient bit per cycle, for the batch mean.
// Uses osce_pkg.
module osce_div import osce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TOTAL_W-1:0] dividend,
    input  logic [ROWS_W-1:0]  divisor,
    output logic               done,
    output logic [TOTAL_W-1:0] quotient
);

    localparam int CNT_W = $clog2(TOTAL_W);

    logic               busy_reg, done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TOTAL_W-1:0] quo_reg;
    logic [ROWS_W-1:0]  rem_reg, dvs_reg;
    logic [ROWS_W:0]    trial;
    logic               fits;

    assign trial    = {rem_reg, quo_reg[TOTAL_W-1]};
    assign fits     = (trial >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg) begin
            quo_reg <= {quo_reg[TOTAL_W-2:0], fits};
            rem_reg <= fits ? ROWS_W'(trial - {1'b0, dvs_reg}) : ROWS_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TOTAL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ hdl/osce_back.sv @@
// Back end: running max, exponent sum, row loss, batch total and mean.
// Uses osce_pkg, osce_ln, osce_div and the assertion macros.
`include "online_softmax_cross_entropy_core_macros.svh"
module osce_back import osce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  osce_in_t  head_item,
    output logic      pop,
    output logic      loss_valid,
    input  logic      loss_stall,
    output osce_out_t loss_item
);

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    back_state_t               state_reg, state_next;
    osce_in_t                  item_reg, item_next;
    logic                      rise_reg, rise_next;
    logic                      big_reg, big_next;
    logic [EXP_W-1:0]          rom_q_reg;
    logic signed [LOGIT_W-1:0] row_max_reg, row_max_next;
    logic signed [LOGIT_W-1:0] target_reg, target_next;
    logic [SUM_W-1:0]          exp_sum_reg, exp_sum_next;
    logic                      started_reg, started_next;
    logic                      sat_reg, sat_next;
    logic [48:0]               prod_reg, prod_next;
    logic [TOTAL_W-1:0]        total_reg, total_next;
    logic [ROWS_W-1:0]         rows_reg, rows_next;
    logic [LOSS_W-1:0]         loss_reg, loss_next;
    logic [LOSS_W-1:0]         mean_reg, mean_next;
    logic                      out_valid_reg, out_valid_next;
    osce_out_t                 out_reg, out_next;

    logic signed [LOGIT_W:0]   diff_up;
    logic [LOGIT_W:0]          d_abs;
    logic                      rise;
    logic [EXP_TABLE_BITS-1:0] rom_addr;
    logic [EXP_W-1:0]          e_val;
    logic [SUM_W:0]            sum_add;
    logic [SUM_W+1:0]          rescale;
    logic signed [LOGIT_W:0]   mt_diff;
    logic signed [24:0]        loss_wide;
    logic [TOTAL_W:0]          total_add;
    logic                      out_free;
    logic                      ln_start, ln_done, div_start, div_done;
    logic [LN_W-1:0]           ln_q;
    logic [TOTAL_W-1:0]        quo;

    assign diff_up  = {head_item.logit[LOGIT_W-1], head_item.logit}
                    - {row_max_reg[LOGIT_W-1], row_max_reg};
    assign rise     = started_reg && (diff_up > 0);
    assign d_abs    = rise ? diff_up : -diff_up;
    assign rom_addr = d_abs[13:EXP_SHIFT];
    assign e_val    = big_reg ? '0 : rom_q_reg;
    assign sum_add  = {1'b0, exp_sum_reg} + (SUM_W+1)'(e_val);
    assign rescale  = (SUM_W+2)'(prod_reg[48:16]) + (SUM_W+2)'(ONE_Q16);
    assign mt_diff  = {row_max_reg[LOGIT_W-1], row_max_reg}
                    - {target_reg[LOGIT_W-1], target_reg};
    assign loss_wide = $signed({5'b0, ln_q}) + $signed({{2{mt_diff[LOGIT_W]}}, mt_diff, 6'b0});
    assign total_add = {1'b0, total_reg} + (TOTAL_W+1)'(loss_reg);
    assign out_free  = !out_valid_reg || !loss_stall;

    assign pop        = (state_reg == BK_IDLE) && head_valid;
    assign ln_start   = (state_reg == BK_LN_GO);
    assign div_start  = (state_reg == BK_DIV_GO);
    assign loss_valid = out_valid_reg;
    assign loss_item  = out_reg;

    always_ff @(posedge clk) begin
        rom_q_reg <= EXP_ROM[rom_addr];
    end

    osce_ln u_ln (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ln_start),
        .x      (exp_sum_reg),
        .done   (ln_done),
        .result (ln_q)
    );

    osce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (rows_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:     if (head_valid) state_next = BK_LOOK;
            BK_LOOK: begin
                if (started_reg && rise_reg)
                    state_next = BK_MUL;
                else
                    state_next = item_reg.last_in_row ? BK_LN_GO : BK_IDLE;
            end
            BK_MUL:      state_next = item_reg.last_in_row ? BK_LN_GO : BK_IDLE;
            BK_LN_GO:    state_next = BK_LN_WAIT;
            BK_LN_WAIT:  if (ln_done) state_next = BK_LOSS;
            BK_LOSS:     state_next = BK_TOT;
            BK_TOT:      state_next = item_reg.last_row ? BK_DIV_GO : BK_OUT;
            BK_DIV_GO:   state_next = BK_DIV_WAIT;
            BK_DIV_WAIT: if (div_done) state_next = BK_OUT;
            BK_OUT:      if (out_free) state_next = BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        item_next      = item_reg;
        rise_next      = rise_reg;
        big_next       = big_reg;
        row_max_next   = row_max_reg;
        target_next    = target_reg;
        exp_sum_next   = exp_sum_reg;
        started_next   = started_reg;
        sat_next       = sat_reg;
        prod_next      = prod_reg;
        total_next     = total_reg;
        rows_next      = rows_reg;
        loss_next      = loss_reg;
        mean_next      = mean_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && loss_stall;
        unique case (state_reg)
            BK_IDLE: begin
                if (head_valid) begin
                    item_next = head_item;
                    rise_next = rise;
                    big_next  = |d_abs[LOGIT_W:14];
                end
            end
            BK_LOOK: begin
                if (!started_reg) begin
                    row_max_next = item_reg.logit;
                    exp_sum_next = ONE_Q16;
                    target_next  = '0;
                    sat_next     = 1'b0;
                    started_next = 1'b1;
                end
                else if (rise_reg) begin
                    prod_next = 49'(exp_sum_reg) * 49'(e_val);
                end
                else if (sum_add[SUM_W]) begin
                    exp_sum_next = SUM_MAX;
                    sat_next     = 1'b1;
                end
                else begin
                    exp_sum_next = sum_add[SUM_W-1:0];
                end
                if (item_reg.is_target)
                    target_next = item_reg.logit;
            end
            BK_MUL: begin
                // A new maximum rescales the old sum and counts itself as 1.0.
                if (rescale[SUM_W+1:SUM_W] != '0) begin
                    exp_sum_next = SUM_MAX;
                    sat_next     = 1'b1;
                end
                else begin
                    exp_sum_next = rescale[SUM_W-1:0];
                end
                row_max_next = item_reg.logit;
            end
            BK_LOSS: begin
                loss_next = loss_wide[24] ? '0 : loss_wide[LOSS_W-1:0];
            end
            BK_TOT: begin
                mean_next = '0;
                if (rows_reg < ROWS_W'(MAX_ROWS)) begin
                    if (total_add[TOTAL_W]) begin
                        total_next = TOTAL_MAX;
                        sat_next   = 1'b1;
                    end
                    else begin
                        total_next = total_add[TOTAL_W-1:0];
                    end
                    rows_next = rows_reg + 1'b1;
                end
            end
            BK_DIV_WAIT: begin
                if (div_done) begin
                    if (rows_reg == '0)
                        mean_next = '0;
                    else if (quo[TOTAL_W-1:LOSS_W] != '0)
                        mean_next = OUT_MAX;
                    else
                        mean_next = quo[LOSS_W-1:0];
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    out_next.row_loss      = loss_reg;
                    out_next.mean_loss     = mean_reg;
                    out_next.is_final      = item_reg.last_row;
                    out_next.sum_saturated = sat_reg;
                    out_valid_next         = 1'b1;
                    started_next           = 1'b0;
                    if (item_reg.last_row) begin
                        total_next = '0;
                        rows_next  = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk) begin
        item_reg <= item_next;
        rise_reg <= rise_next;
        big_reg  <= big_next;
        prod_reg <= prod_next;
        loss_reg <= loss_next;
        mean_reg <= mean_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            row_max_reg   <= '0;
            target_reg    <= '0;
            exp_sum_reg   <= '0;
            started_reg   <= 1'b0;
            sat_reg       <= 1'b0;
            total_reg     <= '0;
            rows_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            row_max_reg   <= row_max_next;
            target_reg    <= target_next;
            exp_sum_reg   <= exp_sum_next;
            started_reg   <= started_next;
            sat_reg       <= sat_next;
            total_reg     <= total_next;
            rows_reg      <= rows_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `OSCE_ASSERT_IMP(a_ln_arg, clk, rst_n, ln_start, exp_sum_reg >= ONE_Q16)
    `OSCE_ASSERT_IMP(a_div_arg, clk, rst_n, div_start, rows_reg != '0)
    `OSCE_ASSERT_IMP(a_ln_done, clk, rst_n, ln_done, state_reg == BK_LN_WAIT)
    `OSCE_ASSERT_IMP(a_div_done, clk, rst_n, div_done, state_reg == BK_DIV_WAIT)
    `OSCE_ASSERT_NEXT(a_row_closed, clk, rst_n, state_reg == BK_OUT && out_free,
        !started_reg && loss_valid)

endmodule
